/* hdl/lir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants for the linear-interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    // fractional phase bits used as interpolation weight
    localparam int FRAC16_W = 16;

    // longest run of output words per input word
    localparam int MAX_RUN = 8;
    localparam int COUNT_W = $clog2(MAX_RUN);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

    localparam int CHAN_W = 4;

    // one interpolation request from the phase sequencer to the lanes
    typedef struct packed {
        logic                valid;
        logic [FRAC16_W-1:0] frac;
        logic                last;
    } lir_issue_t;

endpackage

/* hdl/lir_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_lane
// One channel: holds previous/current sample and computes
// prev + floor((cur - prev) * frac / 2^16) over two register stages.
// ----------------------------------------------------------------------------
module lir_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic                   primed,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   en,
    input  logic                   adv,
    input  lir_pkg::lir_issue_t    iss,
    output logic [SAMPLE_BITS-1:0] y
);
    import lir_pkg::*;

    localparam int D_W    = SAMPLE_BITS + 1;
    localparam int PROD_W = D_W + FRAC16_W + 1;

    logic [SAMPLE_BITS-1:0] cur_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic signed [D_W-1:0]  diff_reg;
    logic signed [D_W-1:0]  diff_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [SAMPLE_BITS-1:0] base_reg;
    logic signed [FRAC16_W:0] frac_s;

    always_comb
    begin
        diff_next = $signed({sample[SAMPLE_BITS-1], sample})
                  - $signed({cur_reg[SAMPLE_BITS-1], cur_reg});
        frac_s    = $signed({1'b0, iss.frac});
        prod_next = PROD_W'(diff_reg * frac_s);
    end

    // frame store; the priming word has no predecessor, so it is its own
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg  <= sample;
            prev_reg <= primed ? cur_reg : sample;
            diff_reg <= primed ? diff_next : '0;
        end
    end

    // product stage; idle lanes carry zeros
    always_ff @(posedge clk)
    begin
        if (adv && iss.valid)
        begin
            prod_reg <= en ? prod_next : '0;
            base_reg <= en ? prev_reg : '0;
        end
    end

    // arithmetic shift by 16, kept modulo the sample width
    assign y = base_reg + prod_reg[FRAC16_W +: SAMPLE_BITS];

endmodule

/* hdl/lir_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_ctrl
// Phase accumulator and run sequencer: one interpolation request per cycle
// if not stalled and the phase is below one, capped at MAX_RUN per input word.
// ----------------------------------------------------------------------------
module lir_ctrl #(
    parameter int FRAC_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 adv,
    input  logic [FRAC_BITS+3:0] step,
    output logic                 ready,
    output logic                 primed,
    output lir_pkg::lir_issue_t  iss
);
    import lir_pkg::*;

    localparam int PHASE_W = FRAC_BITS + 5;
    localparam logic [PHASE_W-1:0] ONE_PHASE = PHASE_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 primed_reg, primed_next;
    logic [PHASE_W-1:0]   sum;
    logic                 below;
    logic                 sum_ge;
    logic                 cap;

    always_comb
    begin
        below  = phase_reg < ONE_PHASE;
        sum    = phase_reg + PHASE_W'(step);
        sum_ge = sum >= ONE_PHASE;
        cap    = count_reg == COUNT_W'(MAX_RUN - 1);

        iss.valid = (state_reg == ST_RUN) && below && adv;
        iss.frac  = phase_reg[FRAC_BITS-1 -: FRAC16_W];
        iss.last  = sum_ge || cap;

        state_next  = state_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        primed_next = primed_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (primed_reg)
                    begin
                        state_next = ST_RUN;
                        count_next = '0;
                    end
                    else
                    begin
                        primed_next = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (!below)
                begin
                    // nothing to emit for this word
                    phase_next = phase_reg - ONE_PHASE;
                    state_next = ST_IDLE;
                end
                else if (adv)
                begin
                    if (iss.last)
                    begin
                        // capped run with phase still short of one clamps to zero
                        phase_next = sum_ge ? sum - ONE_PHASE : '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = sum;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= '0;
            count_reg  <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            primed_reg <= primed_next;
        end
    end

    assign ready  = state_reg == ST_IDLE;
    assign primed = primed_reg;

    a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        iss.valid |-> state_reg == ST_RUN)
        else $error("request issued outside a run");

    a_prime_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !primed_reg) |=> (state_reg == ST_IDLE && primed_reg))
        else $error("priming word started a run");

    a_primed_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && primed_reg) |=> (state_reg == ST_RUN && count_reg == '0))
        else $error("word after priming did not start a run");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (iss.valid && iss.last) |=> state_reg == ST_IDLE)
        else $error("run continued past its last request");

endmodule

/* hdl/linear_interp_resampler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_core
// Multichannel linear-interpolation sample-rate converter with a 5.32
// phase accumulator, one interpolation lane per channel and a merge stage.
// ----------------------------------------------------------------------------
// Path: an input word is taken in the idle state; its first output word
//   passes the sequencer run state, lane product stage and merge register.
// Run: an input word yields N output words, N at most 8, none for the
//   priming word; the phase accumulator steps once per output word and sets N.
// Output stall holds the lane pipeline; the next input is taken once the
//   run has been issued, while results may still drain.
// Reset: rst_n async low clears sequencer, phase, priming flag, valids and
//   sets phase_step to 1.0 and channel_count to 1.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core #(
    parameter int MAX_CHANNELS = 8,
    parameter int FRAC_BITS    = 32,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,

    // fields, lowest bit up: sample_ch0 .. sample_ch(MAX_CHANNELS-1), zero pad
    input  logic [((MAX_CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,

    // fields, lowest bit up: out_ch0 .. out_ch(MAX_CHANNELS-1), zero pad
    output logic [((MAX_CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                          m_tlast,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,

    input  logic                              cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [FRAC_BITS+3:0]              cfg_data
);
    import lir_pkg::*;

    localparam int STEP_W = FRAC_BITS + 4;
    localparam int DATA_W = ((MAX_CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
    localparam int LANE_W = MAX_CHANNELS * SAMPLE_BITS;

    // configuration registers
    logic [STEP_W-1:0] step_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [CHAN_W-1:0] nch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_W'(1) << FRAC_BITS;
            chan_reg <= CHAN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:    step_reg <= cfg_data;
                CFG_CHANNEL_COUNT: chan_reg <= cfg_data[CHAN_W-1:0];
                default:           step_reg <= step_reg;
            endcase
        end
    end

    // zero means one channel, anything above the lane count saturates
    always_comb
    begin
        if (chan_reg == '0)
            nch = CHAN_W'(1);
        else if (chan_reg > CHAN_W'(MAX_CHANNELS))
            nch = CHAN_W'(MAX_CHANNELS);
        else
            nch = chan_reg;
    end

    // pipeline advance: output register free or being drained
    logic       adv;
    logic       accept;
    logic       primed;
    lir_issue_t iss;

    assign adv    = !m_tvalid || m_tready;
    assign accept = s_tvalid && s_tready;

    lir_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .adv    (adv),
        .step   (step_reg),
        .ready  (s_tready),
        .primed (primed),
        .iss    (iss)
    );

    // lanes, one per channel
    logic [LANE_W-1:0] lane_y;

    for (genvar c = 0; c < MAX_CHANNELS; c++)
    begin : g_lane
        lir_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .clk    (clk),
            .load   (accept),
            .primed (primed),
            .sample (s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
            .en     (CHAN_W'(c) < nch),
            .adv    (adv),
            .iss    (iss),
            .y      (lane_y[c*SAMPLE_BITS +: SAMPLE_BITS])
        );
    end

    // stage-1 valid and last mark travel beside the lane products
    logic v1_reg;
    logic last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= iss.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && iss.valid)
            last1_reg <= iss.last;
    end

    // merge stage: gather lane results into the output word
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && v1_reg)
        begin
            m_tdata_reg <= DATA_W'(lane_y);
            m_tlast_reg <= last1_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
